FILE: rtl/core/image_rotate_90_multiples_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame rotator.
// Each macro checks a property on the rising edge of clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef IMAGE_ROTATE_90_MULTIPLES_MACROS_SVH
`define IMAGE_ROTATE_90_MULTIPLES_MACROS_SVH

// Same-cycle implication.
`define IROT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define IROT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/irot90_pkg.sv
// ----------------------------------------------------------------------------
// irot90_pkg
// Types and fixed constants shared by the frame rotator modules.
// ----------------------------------------------------------------------------
package irot90_pkg;

   localparam int POS_W    = 9;
   localparam int SAMPLE_W = 16;
   localparam int DIM_W    = 10;
   localparam int SPP_W    = 3;
   localparam int LANES    = 4;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_90   = 2'd1,
      MODE_180  = 2'd2,
      MODE_270  = 2'd3
   } mode_type;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_READ  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_RANGE       = 2'd1,
      STATUS_UNSUPPORTED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_ROTATION_MODE     = 2'd0,
      REG_SOURCE_WIDTH      = 2'd1,
      REG_SOURCE_HEIGHT     = 2'd2,
      REG_SAMPLES_PER_PIXEL = 2'd3
   } reg_index_type;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 10'd512;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 10'd512;
   localparam logic [SPP_W-1:0] SPP_RESET    = 3'd3;

   typedef struct packed {
      mode_type           mode;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [SPP_W-1:0]   spp;
   } cfg_type;

   typedef struct packed {
      status_type         status;
      logic [LANES-1:0]   lane_en;
      logic               mem_write;
      logic               mem_read;
   } access_type;

endpackage

FILE: rtl/core/irot90_csr.sv
// ----------------------------------------------------------------------------
// irot90_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module irot90_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [irot90_pkg::CSR_AW-1:0]       paddr,
   input  logic [irot90_pkg::CSR_DW-1:0]       pwdata,
   output logic [irot90_pkg::CSR_DW-1:0]       prdata,
   output logic                                pready,
   output irot90_pkg::cfg_type                 cfg
);

   irot90_pkg::mode_type               mode_ff, mode_in;
   logic [irot90_pkg::DIM_W-1:0]       width_ff, width_in;
   logic [irot90_pkg::DIM_W-1:0]       height_ff, height_in;
   logic [irot90_pkg::SPP_W-1:0]       spp_ff, spp_in;
   irot90_pkg::reg_index_type          index;
   logic                               wr_en;

   assign pready = 1'b1;
   assign index  = irot90_pkg::reg_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      spp_in    = spp_ff;
      if (wr_en) begin
         unique case (index)
            irot90_pkg::REG_ROTATION_MODE: begin
               mode_in = irot90_pkg::mode_type'(pwdata[1:0]);
            end
            irot90_pkg::REG_SOURCE_WIDTH: begin
               width_in = pwdata[irot90_pkg::DIM_W-1:0];
            end
            irot90_pkg::REG_SOURCE_HEIGHT: begin
               height_in = pwdata[irot90_pkg::DIM_W-1:0];
            end
            irot90_pkg::REG_SAMPLES_PER_PIXEL: begin
               spp_in = pwdata[irot90_pkg::SPP_W-1:0];
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= irot90_pkg::MODE_NONE;
         width_ff  <= irot90_pkg::WIDTH_RESET;
         height_ff <= irot90_pkg::HEIGHT_RESET;
         spp_ff    <= irot90_pkg::SPP_RESET;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         spp_ff    <= spp_in;
      end
   end

   always_comb begin
      unique case (index)
         irot90_pkg::REG_ROTATION_MODE: begin
            prdata = irot90_pkg::CSR_DW'(mode_ff);
         end
         irot90_pkg::REG_SOURCE_WIDTH: begin
            prdata = irot90_pkg::CSR_DW'(width_ff);
         end
         irot90_pkg::REG_SOURCE_HEIGHT: begin
            prdata = irot90_pkg::CSR_DW'(height_ff);
         end
         irot90_pkg::REG_SAMPLES_PER_PIXEL: begin
            prdata = irot90_pkg::CSR_DW'(spp_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign cfg.mode   = mode_ff;
   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;
   assign cfg.spp    = spp_ff;

endmodule

FILE: rtl/core/irot90_map.sv
// ----------------------------------------------------------------------------
// irot90_map
// Maps a word's position to a frame memory address and decides its status.
// ----------------------------------------------------------------------------
module irot90_map #(
   parameter int MAX_DIM = 512
) (
   input  irot90_pkg::cfg_type                     cfg,
   input  logic                                    req_kind,
   input  logic [irot90_pkg::POS_W-1:0]            req_pos_row,
   input  logic [irot90_pkg::POS_W-1:0]            req_pos_col,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      addr,
   output irot90_pkg::access_type                  acc
);

   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
   localparam int LIM_W  = $clog2(MAX_DIM + 1);
   localparam int EXT_W  = (LIM_W > irot90_pkg::DIM_W) ? LIM_W : irot90_pkg::DIM_W;

   logic [EXT_W-1:0]               w_eff, h_eff, r_ext, c_ext, sr, sc;
   logic                           spp_ok;
   logic [irot90_pkg::SPP_W-1:0]   lanes;
   logic [irot90_pkg::LANES-1:0]   lane_en;
   irot90_pkg::status_type         status;
   irot90_pkg::kind_type           kind;

   assign kind = irot90_pkg::kind_type'(req_kind);

   always_comb begin
      // Sizes above the memory's dimension are clamped to it.
      w_eff = (EXT_W'(cfg.width) > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : EXT_W'(cfg.width);
      h_eff = (EXT_W'(cfg.height) > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM) : EXT_W'(cfg.height);
      r_ext = EXT_W'(req_pos_row);
      c_ext = EXT_W'(req_pos_col);
      spp_ok = (cfg.spp == 3'd1) || (cfg.spp == 3'd3) || (cfg.spp == 3'd4);
      status = irot90_pkg::STATUS_OK;
      sr = r_ext;
      sc = c_ext;
      if (kind == irot90_pkg::KIND_WRITE) begin
         if (r_ext >= h_eff || c_ext >= w_eff) begin
            status = irot90_pkg::STATUS_RANGE;
         end
      end else if (cfg.mode != irot90_pkg::MODE_NONE && !spp_ok) begin
         status = irot90_pkg::STATUS_UNSUPPORTED;
      end else begin
         unique case (cfg.mode)
            irot90_pkg::MODE_NONE: begin
               if (r_ext >= h_eff || c_ext >= w_eff) status = irot90_pkg::STATUS_RANGE;
            end
            irot90_pkg::MODE_90: begin
               if (r_ext >= w_eff || c_ext >= h_eff) status = irot90_pkg::STATUS_RANGE;
               sr = c_ext;
               sc = w_eff - r_ext - EXT_W'(1);
            end
            irot90_pkg::MODE_180: begin
               if (r_ext >= h_eff || c_ext >= w_eff) status = irot90_pkg::STATUS_RANGE;
               sr = h_eff - r_ext - EXT_W'(1);
               sc = w_eff - c_ext - EXT_W'(1);
            end
            irot90_pkg::MODE_270: begin
               if (r_ext >= w_eff || c_ext >= h_eff) status = irot90_pkg::STATUS_RANGE;
               sr = h_eff - c_ext - EXT_W'(1);
               sc = r_ext;
            end
            default: begin
               status = irot90_pkg::STATUS_RANGE;
            end
         endcase
      end
   end

   // In range, both source coordinates are below MAX_DIM, so the cut is lossless.
   assign addr = ADDR_W'(IDX_W'(sr)) * ADDR_W'(MAX_DIM) + ADDR_W'(IDX_W'(sc));

   assign lanes = (cfg.spp > 3'd4) ? 3'd4 : cfg.spp;

   always_comb begin
      for (int k = 0; k < irot90_pkg::LANES; k++) begin
         lane_en[k] = (kind == irot90_pkg::KIND_READ) &&
                      (status == irot90_pkg::STATUS_OK) &&
                      (irot90_pkg::SPP_W'(k) < lanes);
      end
   end

   assign acc.lane_en   = lane_en;
   assign acc.status    = status;
   assign acc.mem_write = (kind == irot90_pkg::KIND_WRITE) && (status == irot90_pkg::STATUS_OK);
   assign acc.mem_read  = (kind == irot90_pkg::KIND_READ) && (status == irot90_pkg::STATUS_OK);

endmodule

FILE: rtl/core/image_rotate_90_multiples.sv
// A result word is valid in the cycle after its request word is accepted.
// Throughput: one word per cycle unless stalled; the single frame memory port
// serves the write or the read of each accepted word at its acceptance edge.
// Reset clears control state and restores the configuration defaults; frame
// memory contents are undefined until written, and no clearing pass runs.
// ----------------------------------------------------------------------------
// image_rotate_90_multiples
// Frame-buffer rotator: stores source pixels and returns pixels of the image
// rotated by a multiple of ninety degrees.
// ----------------------------------------------------------------------------
`include "image_rotate_90_multiples_macros.svh"

module image_rotate_90_multiples #(
   parameter int MAX_DIM     = 512,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic [irot90_pkg::POS_W-1:0]          req_pos_row,
   input  logic [irot90_pkg::POS_W-1:0]          req_pos_col,
   input  logic [irot90_pkg::SAMPLE_W-1:0]       req_in_sample0,
   input  logic [irot90_pkg::SAMPLE_W-1:0]       req_in_sample1,
   input  logic [irot90_pkg::SAMPLE_W-1:0]       req_in_sample2,
   input  logic [irot90_pkg::SAMPLE_W-1:0]       req_in_sample3,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic [irot90_pkg::SAMPLE_W-1:0]       rsp_out_sample0,
   output logic [irot90_pkg::SAMPLE_W-1:0]       rsp_out_sample1,
   output logic [irot90_pkg::SAMPLE_W-1:0]       rsp_out_sample2,
   output logic [irot90_pkg::SAMPLE_W-1:0]       rsp_out_sample3,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [irot90_pkg::CSR_AW-1:0]         paddr,
   input  logic [irot90_pkg::CSR_DW-1:0]         pwdata,
   output logic [irot90_pkg::CSR_DW-1:0]         prdata,
   output logic                                  pready
);

   localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int WORD_W = irot90_pkg::LANES * SAMPLE_BITS;

   irot90_pkg::cfg_type                  cfg;
   irot90_pkg::access_type               acc;
   logic [ADDR_W-1:0]                    addr;
   logic                                 req_accept;
   logic [WORD_W-1:0]                    wdata;

   logic                                 rsp_valid_ff, rsp_valid_in;
   irot90_pkg::status_type               status_ff;
   logic [irot90_pkg::LANES-1:0]         lane_en_ff;
   logic [WORD_W-1:0]                    rd_ff;
   logic [WORD_W-1:0]                    frame_mem [DEPTH];
   logic [irot90_pkg::SAMPLE_W-1:0]      lane_out [irot90_pkg::LANES];

   logic                                 write_accept;
   logic                                 rsp_error;
   logic                                 unsupported;

   irot90_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   irot90_map #(
      .MAX_DIM (MAX_DIM)
   ) u_map (
      .cfg         (cfg),
      .req_kind    (req_kind),
      .req_pos_row (req_pos_row),
      .req_pos_col (req_pos_col),
      .addr        (addr),
      .acc         (acc)
   );

   // The output register frees up when its word is taken in the same cycle.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign wdata = {req_in_sample3[SAMPLE_BITS-1:0], req_in_sample2[SAMPLE_BITS-1:0],
                   req_in_sample1[SAMPLE_BITS-1:0], req_in_sample0[SAMPLE_BITS-1:0]};

   // Each accepted word touches the memory once, at its acceptance edge, so a
   // read always sees every earlier write without forwarding.
   always_ff @(posedge clock) begin
      if (req_accept && acc.mem_write) begin
         frame_mem[addr] <= wdata;
      end
      if (req_accept && acc.mem_read) begin
         rd_ff <= frame_mem[addr];
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff  <= acc.status;
         lane_en_ff <= acc.lane_en;
      end
   end

   always_comb begin
      for (int k = 0; k < irot90_pkg::LANES; k++) begin
         lane_out[k] = lane_en_ff[k] ?
                       irot90_pkg::SAMPLE_W'(rd_ff[k*SAMPLE_BITS +: SAMPLE_BITS]) : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_out_sample0 = lane_out[0];
   assign rsp_out_sample1 = lane_out[1];
   assign rsp_out_sample2 = lane_out[2];
   assign rsp_out_sample3 = lane_out[3];

   assign write_accept = req_accept && (req_kind == irot90_pkg::KIND_WRITE);
   assign rsp_error    = rsp_valid_ff && (status_ff != irot90_pkg::STATUS_OK);
   assign unsupported  = (status_ff == irot90_pkg::STATUS_UNSUPPORTED);

   `IROT_ASSERT_IMP(a_stall_needs_result, req_stall, rsp_valid_ff, "stall without a pending result")
   `IROT_ASSERT_NXT(a_accept_gives_result, req_accept, rsp_valid_ff, "accepted word gave no result")
   `IROT_ASSERT_NXT(a_write_status, write_accept, !unsupported, "write reported unsupported count")
   `IROT_ASSERT_IMP(a_error_no_lanes, rsp_error, lane_en_ff == '0, "error result carries samples")
   `IROT_ASSERT_NXT(a_write_no_lanes, write_accept, lane_en_ff == '0, "write result carries samples")

endmodule
